/* rtl/bsc_pkg.sv */
// Shared types, constants and helpers for the barometric compensation block.
// No dependencies; every other file imports this package.
package bsc_pkg;

	// pipelined divider: one quotient bit per stage
	localparam int DivW   = 32;
	localparam int SideW  = 58;
	// queue between front and back
	localparam int QDepth = 4;
	localparam int QIdxW  = 2;

	// configuration register indexes
	localparam logic [1:0] CfgA   = 2'd0;
	localparam logic [1:0] CfgB   = 2'd1;
	localparam logic [1:0] CfgC   = 2'd2;
	localparam logic [1:0] CfgOss = 2'd3;

	// compensation constants
	localparam logic [31:0] Off4000   = 32'd4000;
	localparam logic [31:0] Bias32768 = 32'd32768;
	localparam logic [31:0] Num50000  = 32'd50000;
	localparam logic [31:0] K3038     = 32'd3038;
	localparam logic [31:0] K7357     = 32'd7357;
	localparam logic [31:0] K3791     = 32'd3791;

	// decoded calibration set
	typedef struct packed {
		logic [15:0] ac1;
		logic [15:0] ac2;
		logic [15:0] ac3;
		logic [15:0] ac4;
		logic [15:0] ac5;
		logic [15:0] ac6;
		logic [15:0] b1;
		logic [15:0] b2;
		logic [15:0] mc;
		logic [15:0] md;
		logic [1:0]  oss;
	} cal_t;

	// item handed from front to back
	typedef struct packed {
		logic [31:0] x1;
		logic [31:0] den;
		logic [23:0] up;
	} fitem_t;

	// sideband through the temperature divider
	typedef struct packed {
		logic [31:0] x1;
		logic [23:0] up;
		logic        dz;
		logic        neg;
	} tside_t;

	// sideband through the pressure divider
	typedef struct packed {
		logic [27:0] temp;
		logic        post;
		logic        err;
	} pside_t;

	// arithmetic right shift of a 32-bit pattern
	function automatic logic [31:0] sar32(input logic [31:0] v, input logic [4:0] n);
		return $signed(v) >>> n;
	endfunction

	// sign-extend a 16-bit field
	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

/* rtl/bsc_front.sv */
// Front end: takes raw readings, computes the first temperature term and divisor.
// Depends on bsc_pkg.
module bsc_front (
	input  bsc_pkg::cal_t   cal,
	input  logic [15:0]     raw_temperature,
	input  logic [23:0]     raw_pressure,
	output bsc_pkg::fitem_t item
);
	import bsc_pkg::*;

	logic [31:0] diff;
	logic [31:0] prod;
	logic [3:0]  pshift;

	// x1 = ((ut - ac6) * ac5) >>> 15, den = x1 + md
	always_comb begin
		diff     = {16'd0, raw_temperature} - {16'd0, cal.ac6};
		prod     = diff * {16'd0, cal.ac5};
		item.x1  = sar32(prod, 5'd15);
		item.den = item.x1 + sx16(cal.md);
		pshift   = 4'd8 - {2'd0, cal.oss};
		item.up  = raw_pressure >> pshift;
	end

endmodule

/* rtl/bsc_fifo.sv */
// Short queue of front items between front and back.
// Depends on bsc_pkg.
module bsc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  bsc_pkg::fitem_t wr_item,
	output logic            full,
	input  logic            rd_en,
	output logic            rd_valid,
	output bsc_pkg::fitem_t rd_item
);
	import bsc_pkg::*;

	fitem_t           mem_q [QDepth];
	logic [QIdxW-1:0] wr_ptr_q;
	logic [QIdxW-1:0] rd_ptr_q;
	logic [QIdxW:0]   cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full     = (cnt_q == (QIdxW+1)'(QDepth));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

/* rtl/bsc_div.sv */
// Pipelined unsigned 32/32 divider, one quotient bit per stage, with sideband.
// Depends on bsc_pkg.
module bsc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [31:0]               num,
	input  logic [31:0]               dvs,
	input  logic [bsc_pkg::SideW-1:0] in_side,
	output logic                      out_valid,
	output logic [31:0]               quo,
	output logic [bsc_pkg::SideW-1:0] out_side
);
	import bsc_pkg::*;

	logic [DivW-1:0]  v_q;
	logic [31:0]      r_q    [DivW];
	logic [31:0]      n_q    [DivW];
	logic [31:0]      d_q    [DivW];
	logic [SideW-1:0] side_q [DivW];
	logic [31:0]      nr     [DivW];
	logic [31:0]      nn     [DivW];
	logic [31:0]      pd_c   [DivW];
	logic [SideW-1:0] ps_c   [DivW];

	// one restoring step per stage; quotient bits shift into the dividend word
	always_comb begin
		logic [31:0] pr;
		logic [31:0] pn;
		logic [32:0] trial;
		for (int k = 0; k < DivW; k++) begin
			if (k == 0) begin
				pr      = '0;
				pn      = num;
				pd_c[k] = dvs;
				ps_c[k] = in_side;
			end else begin
				pr      = r_q[k-1];
				pn      = n_q[k-1];
				pd_c[k] = d_q[k-1];
				ps_c[k] = side_q[k-1];
			end
			trial = {pr, pn[31]};
			if (trial >= {1'b0, pd_c[k]}) begin
				trial = trial - {1'b0, pd_c[k]};
				nn[k] = {pn[30:0], 1'b1};
			end else begin
				nn[k] = {pn[30:0], 1'b0};
			end
			nr[k] = trial[31:0];
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[DivW-2:0], in_valid};
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DivW; k++) begin
				r_q[k]    <= nr[k];
				n_q[k]    <= nn[k];
				d_q[k]    <= pd_c[k];
				side_q[k] <= ps_c[k];
			end
		end
	end

	assign out_valid = v_q[DivW-1];
	assign quo       = n_q[DivW-1];
	assign out_side  = side_q[DivW-1];

endmodule

/* rtl/bsc_back.sv */
// Back end: temperature division, pressure chain, pressure division, output register.
// Depends on bsc_pkg and bsc_div.
module bsc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  bsc_pkg::cal_t   cal,
	input  logic            q_valid,
	input  bsc_pkg::fitem_t q_item,
	output logic            q_pop,
	input  logic            pop,
	output logic            empty,
	output logic [27:0]     temperature_tenths,
	output logic [31:0]     pressure_pa,
	output logic            divide_error
);
	import bsc_pkg::*;

	logic        en;
	logic        out_v_q;

	// whole pipe moves unless a result sits unclaimed
	assign en    = !out_v_q || pop;
	assign q_pop = en && q_valid;
	assign empty = !out_v_q;

	// s1: magnitudes and sign for the temperature division
	logic        v_s1;
	logic [31:0] an_s1, ad_s1, x1_s1;
	logic [23:0] up_s1;
	logic        neg_s1, dz_s1;
	logic [31:0] tn;

	assign tn = sx16(cal.mc) << 11;

	// temperature divider
	logic             va;
	logic [31:0]      qa;
	logic [SideW-1:0] sda;
	tside_t           tsi, tso;

	assign tsi = '{x1: x1_s1, up: up_s1, dz: dz_s1, neg: neg_s1};
	assign tso = tside_t'(sda);

	bsc_div u_tdiv (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.num(an_s1), .dvs(ad_s1), .in_side(tsi),
		.out_valid(va), .quo(qa), .out_side(sda)
	);

	// pressure stage registers
	logic        v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [27:0] temp_s2, temp_s3, temp_s4, temp_s5, temp_s6, temp_s7, temp_s8;
	logic [23:0] up_s2, up_s3, up_s4, up_s5;
	logic        dz_s2, dz_s3, dz_s4, dz_s5, dz_s6, dz_s7, dz_s8;
	logic [31:0] b6_s2;
	logic [31:0] sqp_s3, ac2p_s3, ac3p_s3;
	logic [31:0] sq_s4, x2a_s4, x1c_s4;
	logic [31:0] b2sq_s5, b1sq_s5, x2a_s5, x1c_s5;
	logic [31:0] b3_s6, t_s6;
	logic [23:0] up_s6;
	logic [31:0] b4p_s7, dup_s7;
	logic [31:0] b4_s8, b7_s8;

	logic [31:0] x2t, b5, b5r, sum6, sh6, b3c, x3c;

	always_comb begin
		// quotient sign fix, b5 and rounded temperature
		x2t  = tso.neg ? (32'd0 - qa) : qa;
		b5   = tso.x1 + x2t;
		b5r  = sar32(b5 + 32'd8, 5'd4);
		// b3 for b7 and x3 for b4
		sum6 = (sx16(cal.ac1) << 2) + sar32(b2sq_s5, 5'd11) + x2a_s5;
		sh6  = sum6 << cal.oss;
		b3c  = sar32(sh6 + 32'd2, 5'd2);
		x3c  = sar32(x1c_s5 + sar32(b1sq_s5, 5'd16) + 32'd2, 5'd2);
	end

	// pressure divider inputs
	logic             vb;
	logic [31:0]      qb;
	logic [SideW-1:0] sdb;
	logic [31:0]      pn;
	pside_t           psi, pso;

	assign pn  = b7_s8[31] ? b7_s8 : (b7_s8 << 1);
	assign psi = '{temp: temp_s8, post: b7_s8[31], err: dz_s8 || (b4_s8 == 32'd0)};
	assign pso = pside_t'(sdb[$bits(pside_t)-1:0]);

	bsc_div u_pdiv (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s8),
		.num(pn), .dvs(b4_s8), .in_side({{(SideW-$bits(pside_t)){1'b0}}, psi}),
		.out_valid(vb), .quo(qb), .out_side(sdb)
	);

	// final correction stages
	logic        v_s10, v_s11, v_s12;
	logic [27:0] temp_s10, temp_s11, temp_s12;
	logic        err_s10, err_s11, err_s12;
	logic [31:0] p_s10, p_s11, p_s12;
	logic [31:0] m1_s11, m2_s11, m3_s12, x2_s12;
	logic [31:0] sp, pres;

	assign sp   = sar32(p_s10, 5'd8);
	assign pres = p_s12 + sar32(sar32(m3_s12, 5'd16) + x2_s12 + K3791, 5'd4);

	logic [27:0] temp_q;
	logic [31:0] pres_q;
	logic        err_q;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= q_valid;
			v_s2 <= va;   v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
			v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
			v_s10 <= vb;  v_s11 <= v_s10; v_s12 <= v_s11;
			out_v_q <= v_s12;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			// s1
			neg_s1 <= tn[31] ^ q_item.den[31];
			an_s1  <= tn[31] ? (32'd0 - tn) : tn;
			ad_s1  <= q_item.den[31] ? (32'd0 - q_item.den) : q_item.den;
			dz_s1  <= (q_item.den == 32'd0);
			x1_s1  <= q_item.x1;
			up_s1  <= q_item.up;
			// s2
			temp_s2 <= b5r[27:0];
			b6_s2   <= b5 - Off4000;
			up_s2   <= tso.up;
			dz_s2   <= tso.dz;
			// s3: squares and coefficient products of b6
			sqp_s3  <= b6_s2 * b6_s2;
			ac2p_s3 <= sx16(cal.ac2) * b6_s2;
			ac3p_s3 <= sx16(cal.ac3) * b6_s2;
			temp_s3 <= temp_s2; up_s3 <= up_s2; dz_s3 <= dz_s2;
			// s4
			sq_s4   <= sar32(sqp_s3, 5'd12);
			x2a_s4  <= sar32(ac2p_s3, 5'd11);
			x1c_s4  <= sar32(ac3p_s3, 5'd13);
			temp_s4 <= temp_s3; up_s4 <= up_s3; dz_s4 <= dz_s3;
			// s5
			b2sq_s5 <= sx16(cal.b2) * sq_s4;
			b1sq_s5 <= sx16(cal.b1) * sq_s4;
			x2a_s5  <= x2a_s4;
			x1c_s5  <= x1c_s4;
			temp_s5 <= temp_s4; up_s5 <= up_s4; dz_s5 <= dz_s4;
			// s6
			b3_s6   <= b3c;
			t_s6    <= x3c + Bias32768;
			temp_s6 <= temp_s5; up_s6 <= up_s5; dz_s6 <= dz_s5;
			// s7
			b4p_s7  <= {16'd0, cal.ac4} * t_s6;
			dup_s7  <= {8'd0, up_s6} - b3_s6;
			temp_s7 <= temp_s6; dz_s7 <= dz_s6;
			// s8
			b4_s8   <= b4p_s7 >> 15;
			b7_s8   <= dup_s7 * (Num50000 >> cal.oss);
			temp_s8 <= temp_s7; dz_s8 <= dz_s7;
			// s10
			p_s10    <= pso.post ? (qb << 1) : qb;
			temp_s10 <= pso.temp; err_s10 <= pso.err;
			// s11
			m1_s11   <= sp * sp;
			m2_s11   <= K7357 * p_s10;
			p_s11    <= p_s10; temp_s11 <= temp_s10; err_s11 <= err_s10;
			// s12
			m3_s12   <= m1_s11 * K3038;
			x2_s12   <= sar32(32'd0 - m2_s11, 5'd16);
			p_s12    <= p_s11; temp_s12 <= temp_s11; err_s12 <= err_s11;
			// output register
			temp_q <= err_s12 ? 28'd0 : temp_s12;
			pres_q <= err_s12 ? 32'd0 : pres;
			err_q  <= err_s12;
		end
	end

	assign temperature_tenths = temp_q;
	assign pressure_pa        = pres_q;
	assign divide_error       = err_q;

endmodule

/* rtl/barometric_sensor_compensation.sv */
// Top level: configuration registers, front end, queue and back end.
// Depends on bsc_pkg, bsc_front, bsc_fifo, bsc_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | push / full        | raw_temperature, raw_pressure
//  result   | empty / pop        | temperature_tenths, pressure_pa, divide_error
//  config   | cfg_wr_en          | cfg_index, cfg_wdata
//
// One beat per cycle in steady state while results are popped. From accept
// to empty going low: the queue, one setup stage, two 32-stage dividers (one
// quotient bit per stage), ten arithmetic stages and the output register.
// Reset clears all valid bits, the queue and the calibration registers.
// A held result stalls the whole back pipe; the four-entry queue keeps
// taking beats until it fills.
module barometric_sensor_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] raw_temperature,
	input  logic [23:0] raw_pressure,
	output logic        empty,
	input  logic        pop,
	output logic [27:0] temperature_tenths,
	output logic [31:0] pressure_pa,
	output logic        divide_error,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);
	import bsc_pkg::*;

	logic [63:0] cal_a_q;
	logic [63:0] cal_b_q;
	logic [31:0] cal_c_q;
	logic [1:0]  oss_q;
	cal_t        cal;
	fitem_t      f_item, q_item;
	logic        q_valid, q_pop;

	// calibration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
			oss_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CfgA:    cal_a_q <= cfg_wdata;
				CfgB:    cal_b_q <= cfg_wdata;
				CfgC:    cal_c_q <= cfg_wdata[31:0];
				CfgOss:  oss_q   <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// field decode
	assign cal = '{ac1: cal_a_q[63:48], ac2: cal_a_q[47:32], ac3: cal_a_q[31:16],
		ac4: cal_a_q[15:0], ac5: cal_b_q[63:48], ac6: cal_b_q[47:32],
		b1: cal_b_q[31:16], b2: cal_b_q[15:0], mc: cal_c_q[31:16],
		md: cal_c_q[15:0], oss: oss_q};

	bsc_front u_front (
		.cal(cal), .raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
		.item(f_item)
	);

	bsc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_en(push), .wr_item(f_item), .full(full),
		.rd_en(q_pop), .rd_valid(q_valid), .rd_item(q_item)
	);

	bsc_back u_back (
		.clk(clk), .arst_n(arst_n), .cal(cal), .q_valid(q_valid), .q_item(q_item),
		.q_pop(q_pop), .pop(pop), .empty(empty),
		.temperature_tenths(temperature_tenths), .pressure_pa(pressure_pa),
		.divide_error(divide_error)
	);

	// an error result carries zero values
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && divide_error) |-> (temperature_tenths == '0 && pressure_pa == '0))
		else $error("error result with nonzero values");

	// an unclaimed result stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result dropped without pop");

	// a full queue holds items for the back end
	a_full_valid: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_valid)
		else $error("queue full but reads empty");

endmodule
